@@ rtl/bcda_pkg.sv @@
package bcda_pkg;

   localparam int DEV_W  = 8;
   localparam int BLK_W  = 32;
   localparam int SIZE_W = 16;
   localparam int TAG_W  = DEV_W + BLK_W + SIZE_W;
   localparam int FUNC_W = 2;

   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_FLUSH = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_NONE  = 2'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_SCAN_END,
      ST_DECIDE,
      ST_VICTIM,
      ST_RESP,
      ST_FL_READ,
      ST_FL_CHECK,
      ST_FL_SEND
   } state_type;

   typedef struct packed {
      logic capture;
      logic issue;
      logic rd_victim;
      logic commit;
      logic out_zero;
      logic flush_emit;
   } cmd_type;

   typedef struct packed {
      logic is_flush;
      logic is_access;
      logic hit_found;
      logic alloc;
      logic any_dirty;
      logic flush_here;
      logic flush_last;
   } sts_type;

endpackage

@@ rtl/bcda_req_if.sv @@
interface bcda_req_if;
   import bcda_pkg::*;
   logic                valid;
   logic                ready;
   logic [FUNC_W-1:0]   func;
   logic [DEV_W-1:0]    device_id;
   logic [BLK_W-1:0]    block_number;
   logic [SIZE_W-1:0]   block_size;
   logic                allocate_on_miss;

   modport source (output valid, func, device_id, block_number, block_size,
                   allocate_on_miss, input ready);
   modport sink (input valid, func, device_id, block_number, block_size,
                 allocate_on_miss, output ready);
endinterface

@@ rtl/bcda_rsp_if.sv @@
interface bcda_rsp_if #(parameter int IDX_W = 4);
   import bcda_pkg::*;
   logic                valid;
   logic                ready;
   logic                hit;
   logic [IDX_W-1:0]    entry_index;
   logic                filled;
   logic                writeback_valid;
   logic [DEV_W-1:0]    writeback_device;
   logic [BLK_W-1:0]    writeback_block;
   logic [SIZE_W-1:0]   writeback_size;
   logic                last;

   modport source (output valid, hit, entry_index, filled, writeback_valid,
                   writeback_device, writeback_block, writeback_size, last,
                   input ready);
   modport sink (input valid, hit, entry_index, filled, writeback_valid,
                 writeback_device, writeback_block, writeback_size, last,
                 output ready);
endinterface

@@ rtl/bcda_ram.sv @@
module bcda_ram #(
   parameter int WIDTH = 56,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

@@ rtl/bcda_ctrl.sv @@
module bcda_ctrl #(
   parameter int ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  bcda_pkg::sts_type          sts,
   output bcda_pkg::cmd_type          cmd,
   output logic [$clog2(ENTRIES)-1:0] idx
);
   import bcda_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_DISPATCH;
         ST_DISPATCH: begin
            if (sts.is_access) state_in = ST_SCAN;
            else if (sts.is_flush && sts.any_dirty) state_in = ST_FL_READ;
            else state_in = ST_RESP;
         end
         ST_SCAN:     if (idx_ff == LAST_IDX) state_in = ST_SCAN_END;
         ST_SCAN_END: state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (sts.hit_found || !sts.alloc) state_in = ST_RESP;
            else state_in = ST_VICTIM;
         end
         ST_VICTIM:   state_in = ST_RESP;
         ST_RESP:     if (rsp_ready) state_in = ST_IDLE;
         ST_FL_READ:  state_in = ST_FL_CHECK;
         ST_FL_CHECK: begin
            if (sts.flush_here) state_in = ST_FL_SEND;
            else state_in = ST_FL_READ;
         end
         ST_FL_SEND: begin
            if (rsp_ready) state_in = sts.flush_last ? ST_IDLE : ST_FL_READ;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      idx_in    = idx_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
            idx_in      = '0;
         end
         ST_DISPATCH: cmd.out_zero = !sts.is_access && !(sts.is_flush && sts.any_dirty);
         ST_SCAN: begin
            cmd.issue = 1'b1;
            idx_in    = idx_ff + 1'b1;
         end
         ST_SCAN_END: idx_in = '0;
         ST_DECIDE: begin
            cmd.commit    = sts.hit_found || !sts.alloc;
            cmd.rd_victim = !(sts.hit_found || !sts.alloc);
         end
         ST_VICTIM:   cmd.commit = 1'b1;
         ST_RESP:     rsp_valid = 1'b1;
         ST_FL_READ:  ;
         ST_FL_CHECK: begin
            cmd.flush_emit = sts.flush_here;
            if (!sts.flush_here) idx_in = idx_ff + 1'b1;
         end
         ST_FL_SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready && !sts.flush_last) idx_in = idx_ff + 1'b1;
         end
         default: ;
      endcase
   end

   assign idx = idx_ff;
endmodule

@@ rtl/bcda_dp.sv @@
module bcda_dp #(
   parameter int ENTRIES   = 16,
   parameter int AGE_LIMIT = 255
) (
   input  logic                       clock,
   input  logic                       reset,
   input  bcda_pkg::cmd_type          cmd,
   input  logic [$clog2(ENTRIES)-1:0] idx,
   output bcda_pkg::sts_type          sts,
   input  logic [bcda_pkg::FUNC_W-1:0] in_func,
   input  logic [bcda_pkg::TAG_W-1:0] in_tag,
   input  logic                       in_alloc,
   output logic                       out_hit,
   output logic [$clog2(ENTRIES)-1:0] out_index,
   output logic                       out_filled,
   output logic                       out_wb_valid,
   output logic [bcda_pkg::TAG_W-1:0] out_wb_tag,
   output logic                       out_last
);
   import bcda_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);
   localparam int AGE_W = $clog2(AGE_LIMIT + 1);
   localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(AGE_LIMIT);

   logic [FUNC_W-1:0] func_ff;
   logic [TAG_W-1:0]  tag_ff;
   logic              alloc_ff;
   logic [ENTRIES-1:0] valid_ff, dirty_ff;
   logic [AGE_W-1:0]  age_ff [ENTRIES];
   logic              cmp_vld_ff;
   logic [IDX_W-1:0]  cmp_idx_ff;
   logic              hit_found_ff, free_found_ff;
   logic [IDX_W-1:0]  hit_idx_ff, victim_ff;
   logic [AGE_W-1:0]  oldest_ff;
   logic [1:0]        zcnt_ff;

   logic [TAG_W-1:0]  rd_data;
   logic [IDX_W-1:0]  rd_addr;
   logic              ram_we;
   logic [ENTRIES-1:0] dv;
   logic              above;
   logic [IDX_W-1:0]  touch_idx;
   logic              others_zero;
   logic              match;
   logic              victim_wb;

   assign rd_addr = cmd.rd_victim ? victim_ff : idx;
   assign ram_we  = cmd.commit && !hit_found_ff && alloc_ff;

   bcda_ram #(.WIDTH(TAG_W), .DEPTH(ENTRIES)) u_tag_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (victim_ff),
      .wdata (tag_ff),
      .raddr (rd_addr),
      .rdata (rd_data)
   );

   assign dv = valid_ff & dirty_ff;

   always_comb begin
      above = 1'b0;
      for (int k = 0; k < ENTRIES; k++) begin
         if (IDX_W'(k) > idx && dv[k]) above = 1'b1;
      end
   end

   assign match       = valid_ff[cmp_idx_ff] && (rd_data == tag_ff);
   assign touch_idx   = hit_found_ff ? hit_idx_ff : victim_ff;
   assign others_zero = (zcnt_ff == 2'd2) ||
                        ((zcnt_ff == 2'd1) &&
                         !(valid_ff[touch_idx] && age_ff[touch_idx] == '0));
   assign victim_wb   = valid_ff[victim_ff] && dirty_ff[victim_ff];

   assign sts.is_flush   = (func_ff == FUNC_FLUSH);
   assign sts.is_access  = (func_ff == FUNC_READ) || (func_ff == FUNC_WRITE);
   assign sts.hit_found  = hit_found_ff;
   assign sts.alloc      = alloc_ff;
   assign sts.any_dirty  = |dv;
   assign sts.flush_here = dv[idx];
   assign sts.flush_last = !above;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         func_ff       <= in_func;
         tag_ff        <= in_tag;
         alloc_ff      <= in_alloc;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         hit_idx_ff    <= '0;
         victim_ff     <= '0;
         oldest_ff     <= '0;
         zcnt_ff       <= '0;
      end else if (cmp_vld_ff) begin
         if (match && !hit_found_ff) begin
            hit_found_ff <= 1'b1;
            hit_idx_ff   <= cmp_idx_ff;
         end
         if (!free_found_ff) begin
            if (!valid_ff[cmp_idx_ff]) begin
               free_found_ff <= 1'b1;
               victim_ff     <= cmp_idx_ff;
            end else if (age_ff[cmp_idx_ff] >= oldest_ff) begin
               oldest_ff <= age_ff[cmp_idx_ff];
               victim_ff <= cmp_idx_ff;
            end
         end
         if (valid_ff[cmp_idx_ff] && age_ff[cmp_idx_ff] == '0 && zcnt_ff != 2'd2) begin
            zcnt_ff <= zcnt_ff + 2'd1;
         end
      end
      cmp_idx_ff <= idx;

      if (cmd.out_zero || (cmd.commit && !hit_found_ff && !alloc_ff)) begin
         out_hit      <= 1'b0;
         out_index    <= '0;
         out_filled   <= 1'b0;
         out_wb_valid <= 1'b0;
         out_wb_tag   <= '0;
         out_last     <= 1'b1;
      end else if (cmd.commit && hit_found_ff) begin
         out_hit      <= 1'b1;
         out_index    <= hit_idx_ff;
         out_filled   <= 1'b0;
         out_wb_valid <= 1'b0;
         out_wb_tag   <= '0;
         out_last     <= 1'b1;
      end else if (cmd.commit) begin
         out_hit      <= 1'b0;
         out_index    <= victim_ff;
         out_filled   <= 1'b1;
         out_wb_valid <= victim_wb;
         out_wb_tag   <= victim_wb ? rd_data : '0;
         out_last     <= 1'b1;
      end else if (cmd.flush_emit) begin
         out_hit      <= 1'b0;
         out_index    <= idx;
         out_filled   <= 1'b0;
         out_wb_valid <= 1'b1;
         out_wb_tag   <= rd_data;
         out_last     <= !above;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         dirty_ff   <= '0;
         cmp_vld_ff <= 1'b0;
         for (int k = 0; k < ENTRIES; k++) age_ff[k] <= '0;
      end else begin
         cmp_vld_ff <= cmd.issue;
         if (cmd.flush_emit) begin
            dirty_ff[idx] <= 1'b0;
         end
         if (cmd.commit && (hit_found_ff || alloc_ff)) begin
            if (hit_found_ff) begin
               if (func_ff == FUNC_WRITE) dirty_ff[hit_idx_ff] <= 1'b1;
            end else begin
               valid_ff[victim_ff] <= 1'b1;
               dirty_ff[victim_ff] <= 1'b0;
            end
            for (int k = 0; k < ENTRIES; k++) begin
               if (IDX_W'(k) == touch_idx) age_ff[k] <= '0;
               else if (others_zero && age_ff[k] < AGE_MAX) age_ff[k] <= age_ff[k] + 1'b1;
            end
         end
      end
   end
endmodule

@@ rtl/block_cache_directory_aging.sv @@
// Directory of a fully associative write-back block cache with aging
// replacement.
// req_ch carries one transaction per command: read, write, flush or none, with
// the device, block number and block size tag and the allocate flag.
// rsp_ch returns the results: one per access, one per dirty entry on a
// flush (or a single empty result when nothing is dirty, and for none), last marking
// the final one of each command.
// An access scans the tag memory one entry a cycle, as the single read port
// of the tag memory allows; a fill also reads the victim's old tag before
// the result is registered.
// A flush is dispatched, then reads and checks each entry in turn up to the
// last dirty one, sending a result for each dirty one while the receiver is ready.
// One command is in flight at a time; req_ch.ready is high only when the
// previous command's results have all been taken.
// A stalled receiver holds the result in the output register, and the
// block waits.
// Reset clears all valid, dirty and age state at once; no clearing pass.
module block_cache_directory_aging #(
   parameter int ENTRIES   = 16,
   parameter int AGE_LIMIT = 255
) (
   input logic         clock,
   input logic         reset,
   bcda_req_if.sink    req_ch,
   bcda_rsp_if.source  rsp_ch
);
   import bcda_pkg::*;

   localparam int IDX_W = $clog2(ENTRIES);

   cmd_type          cmd;
   sts_type          sts;
   logic [IDX_W-1:0] idx;
   logic [TAG_W-1:0] wb_tag;

   bcda_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .sts       (sts),
      .cmd       (cmd),
      .idx       (idx)
   );

   bcda_dp #(.ENTRIES(ENTRIES), .AGE_LIMIT(AGE_LIMIT)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .idx          (idx),
      .sts          (sts),
      .in_func      (req_ch.func),
      .in_tag       ({req_ch.device_id, req_ch.block_number, req_ch.block_size}),
      .in_alloc     (req_ch.allocate_on_miss),
      .out_hit      (rsp_ch.hit),
      .out_index    (rsp_ch.entry_index),
      .out_filled   (rsp_ch.filled),
      .out_wb_valid (rsp_ch.writeback_valid),
      .out_wb_tag   (wb_tag),
      .out_last     (rsp_ch.last)
   );

   assign rsp_ch.writeback_device = wb_tag[TAG_W-1 -: DEV_W];
   assign rsp_ch.writeback_block  = wb_tag[SIZE_W +: BLK_W];
   assign rsp_ch.writeback_size   = wb_tag[SIZE_W-1:0];

`ifndef SYNTH
   a_no_accept_during_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> !rsp_ch.valid)
      else $error("command accepted while a result is pending");
   a_fill_not_hit: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.filled) |-> !rsp_ch.hit)
      else $error("result both hit and filled");
   a_commit_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.commit && cmd.flush_emit))
      else $error("commit and flush emit together");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.ready) |=> (rsp_ch.valid && $stable(rsp_ch.entry_index)))
      else $error("stalled result changed");
`endif
endmodule
